### rtl/facet_height_flatten_assert.svh
// Assertion macros for the facet height flatten block.
`ifndef FACET_HEIGHT_FLATTEN_ASSERT_SVH
`define FACET_HEIGHT_FLATTEN_ASSERT_SVH
`ifndef SYNTH
`define FHF_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FHF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FHF_ASSERT(label, clk, rst_n, cond, msg)
`define FHF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/fhf_pkg.sv
// Shared types and constants of the facet height flatten block.
`default_nettype none
package fhf_pkg;

  localparam int HW        = 32;
  localparam int DW        = HW + 1;
  localparam int POS_W     = 14;
  localparam int FACET_W   = 5;
  localparam int OFS_W     = 5;
  localparam int STR_W     = 17;
  localparam int WT_W      = 17;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int INFL_W    = 2;

  localparam int QDEPTH    = 8;
  localparam int QIDX_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QIDX_W + 1;

  localparam logic [FACET_W-1:0] FACET_MIN = FACET_W'(2);
  localparam logic [FACET_W-1:0] MAX_FACET = FACET_W'(16);
  localparam logic [FACET_W-1:0] FACET_RST = FACET_W'(4);
  localparam logic [STR_W-1:0]   STR_ONE   = STR_W'(65536);

  localparam logic REG_FACET    = 1'b0;
  localparam logic REG_STRENGTH = 1'b1;

  typedef struct packed {
    logic [FACET_W-1:0] facet_size;
    logic [STR_W-1:0]   strength;
  } cfg_t;

  typedef struct packed {
    logic [HW-1:0]    base;
    logic [DW-1:0]    d1;
    logic [DW-1:0]    d2;
    logic [OFS_W-1:0] m1;
    logic [OFS_W-1:0] m2;
    logic [HW-1:0]    cur;
    logic [STR_W-1:0] t;
    logic             changed;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

endpackage
`default_nettype wire

### rtl/fhf_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module fhf_regs import fhf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [FACET_W-1:0] facet_r, facet_nxt;
  logic [STR_W-1:0]   str_r, str_nxt;
  logic               wr;
  logic               idx;
  logic [FACET_W-1:0] fv;
  logic [STR_W-1:0]   sv;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[ADDR_W-1];
  assign fv     = pwdata[FACET_W-1:0];
  assign sv     = pwdata[STR_W-1:0];

  always_comb begin
    facet_nxt = facet_r;
    str_nxt   = str_r;
    if (wr) begin
      case (idx)
        REG_FACET: begin
          if (fv < FACET_MIN) facet_nxt = FACET_MIN;
          else if (fv > MAX_FACET) facet_nxt = MAX_FACET;
          else facet_nxt = fv;
        end
        REG_STRENGTH: begin
          str_nxt = (sv > STR_ONE) ? STR_ONE : sv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      facet_r <= FACET_RST;
      str_r   <= STR_ONE;
    end else begin
      facet_r <= facet_nxt;
      str_r   <= str_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_FACET:    prdata = {{(DATA_W-FACET_W){1'b0}}, facet_r};
      REG_STRENGTH: prdata = {{(DATA_W-STR_W){1'b0}}, str_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.facet_size = facet_r;
  assign cfg.strength   = str_r;

endmodule
`default_nettype wire

### rtl/fhf_front.sv
// Front end: cell offsets, triangle choice and blend factor per pixel.
`default_nettype none
module fhf_front import fhf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             acc,
  input  wire logic [POS_W-1:0] pos_x,
  input  wire logic [POS_W-1:0] pos_y,
  input  wire logic [HW-1:0]    height_a,
  input  wire logic [HW-1:0]    height_b,
  input  wire logic [HW-1:0]    height_c,
  input  wire logic [HW-1:0]    height_d,
  input  wire logic [HW-1:0]    current_height,
  input  wire logic [WT_W-1:0]  pixel_weight,
  output logic                  push,
  output job_t                  job,
  output logic [INFL_W-1:0]     inflight
);

  localparam int RECIP_W = 18;
  localparam int QP_W    = POS_W + RECIP_W;
  localparam int WS_W    = WT_W + STR_W;
  localparam logic [WS_W-1:0] RND_HALF = WS_W'(32768);

  function automatic logic [RECIP_W-1:0] recip(input logic [FACET_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      5'd2:    r = 18'd131072;
      5'd3:    r = 18'd87382;
      5'd4:    r = 18'd65536;
      5'd5:    r = 18'd52429;
      5'd6:    r = 18'd43691;
      5'd7:    r = 18'd37450;
      5'd8:    r = 18'd32768;
      5'd9:    r = 18'd29128;
      5'd10:   r = 18'd26215;
      5'd11:   r = 18'd23832;
      5'd12:   r = 18'd21846;
      5'd13:   r = 18'd20165;
      5'd14:   r = 18'd18725;
      5'd15:   r = 18'd17477;
      5'd16:   r = 18'd16384;
      default: r = 18'd65536;
    endcase
    return r;
  endfunction

  logic [RECIP_W-1:0] rcp;
  logic [QP_W-1:0]    qx_prod, qy_prod;
  logic [WT_W-1:0]    wt_cl;
  logic [WS_W-1:0]    ws_prod, ws_rnd;

  logic               v1_r, v2_r, v3_r;
  logic [POS_W-1:0]   x1_r, y1_r, qx1_r, qy1_r;
  logic [HW-1:0]      ha1_r, hb1_r, hc1_r, hd1_r, cur1_r;
  logic [WS_W-1:0]    ws1_r;
  logic               chg1_r;

  logic [POS_W-1:0]   rx, ry;
  logic [OFS_W-1:0]   du2_r, dv2_r;
  logic [HW-1:0]      ha2_r, hb2_r, hc2_r, hd2_r, cur2_r;
  logic [STR_W-1:0]   t2_r;
  logic               chg2_r;

  logic [OFS_W:0]     uv_sum;
  logic               abc;
  logic [DW-1:0]      sa, sb, sc, sd;
  job_t               job_nxt, job_r;

  assign rcp     = recip(cfg.facet_size);
  assign qx_prod = {{RECIP_W{1'b0}}, pos_x} * {{POS_W{1'b0}}, rcp};
  assign qy_prod = {{RECIP_W{1'b0}}, pos_y} * {{POS_W{1'b0}}, rcp};
  assign wt_cl   = (pixel_weight > STR_ONE) ? STR_ONE : pixel_weight;
  assign ws_prod = {{STR_W{1'b0}}, wt_cl} * {{WT_W{1'b0}}, cfg.strength};

  always_ff @(posedge clk) begin
    x1_r   <= pos_x;
    y1_r   <= pos_y;
    qx1_r  <= qx_prod[QP_W-1:RECIP_W];
    qy1_r  <= qy_prod[QP_W-1:RECIP_W];
    ha1_r  <= height_a;
    hb1_r  <= height_b;
    hc1_r  <= height_c;
    hd1_r  <= height_d;
    cur1_r <= current_height;
    ws1_r  <= ws_prod;
    chg1_r <= (wt_cl != '0);
  end

  assign rx     = x1_r - qx1_r * {{(POS_W-FACET_W){1'b0}}, cfg.facet_size};
  assign ry     = y1_r - qy1_r * {{(POS_W-FACET_W){1'b0}}, cfg.facet_size};
  assign ws_rnd = ws1_r + RND_HALF;

  always_ff @(posedge clk) begin
    du2_r  <= rx[OFS_W-1:0];
    dv2_r  <= ry[OFS_W-1:0];
    ha2_r  <= ha1_r;
    hb2_r  <= hb1_r;
    hc2_r  <= hc1_r;
    hd2_r  <= hd1_r;
    cur2_r <= cur1_r;
    t2_r   <= ws_rnd[16+STR_W-1:16];
    chg2_r <= chg1_r;
  end

  assign uv_sum = {1'b0, du2_r} + {1'b0, dv2_r};
  assign abc    = (uv_sum <= {1'b0, cfg.facet_size});
  assign sa     = {ha2_r[HW-1], ha2_r};
  assign sb     = {hb2_r[HW-1], hb2_r};
  assign sc     = {hc2_r[HW-1], hc2_r};
  assign sd     = {hd2_r[HW-1], hd2_r};

  always_comb begin
    job_nxt.cur     = cur2_r;
    job_nxt.t       = t2_r;
    job_nxt.changed = chg2_r;
    if (abc) begin
      job_nxt.base = ha2_r;
      job_nxt.m1   = du2_r;
      job_nxt.d1   = sb - sa;
      job_nxt.m2   = dv2_r;
      job_nxt.d2   = sc - sa;
    end else begin
      job_nxt.base = hd2_r;
      job_nxt.m1   = cfg.facet_size - du2_r;
      job_nxt.d1   = sc - sd;
      job_nxt.m2   = cfg.facet_size - dv2_r;
      job_nxt.d2   = sb - sd;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign push     = v3_r;
  assign job      = job_r;
  assign inflight = {1'b0, v1_r} + {1'b0, v2_r} + {1'b0, v3_r};

endmodule
`default_nettype wire

### rtl/fhf_queue.sv
// Job queue between the front end and the back end.
`default_nettype none
module fhf_queue import fhf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output qstat_t    stat
);

  job_t              mem_r [QDEPTH];
  logic [QIDX_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (cnt_r != QCNT_W'(QDEPTH));
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_job;
  end

  assign head       = mem_r[rp_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

### rtl/fhf_back.sv
// Back end: facet plane interpolation, rounded divide by the cell size, blend.
`default_nettype none
module fhf_back import fhf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        take,
  input  wire job_t        job,
  output logic             res_strobe,
  output logic [HW-1:0]    res_new_height,
  output logic [HW-1:0]    res_facet_height,
  output logic             res_changed
);

  localparam int PW    = DW + OFS_W + 1;
  localparam int NW    = PW + 2;
  localparam int UW    = NW - 1;
  localparam int CH    = 8;
  localparam int NDIV  = UW / CH;
  localparam int RW    = FACET_W + 1;
  localparam int FW    = UW + 1;
  localparam int PRW   = DW + STR_W + 1;
  localparam logic signed [PRW-1:0] RND_HALF = PRW'(32768);

  typedef struct packed {
    logic [HW-1:0]    base;
    logic [HW-1:0]    cur;
    logic [STR_W-1:0] t;
    logic             changed;
  } side_t;

  function automatic logic [RW+CH-1:0] div_step(input logic [RW-1:0] rem_in,
                                                input logic [CH-1:0] chunk,
                                                input logic [RW-1:0] d);
    logic [RW-1:0] rem;
    logic [RW-1:0] tv;
    logic [CH-1:0] q;
    rem = rem_in;
    q   = '0;
    for (int i = CH - 1; i >= 0; i--) begin
      tv = {rem[RW-2:0], chunk[i]};
      if (tv >= d) begin
        rem  = tv - d;
        q[i] = 1'b1;
      end else begin
        rem  = tv;
      end
    end
    return {rem, q};
  endfunction

  function automatic logic [HW-1:0] sat_hw(input logic [FW-1:0] v);
    logic [FW-HW:0] top;
    top = v[FW-1:HW-1];
    if ((&top) || !(|top)) return v[HW-1:0];
    else if (v[FW-1]) return {1'b1, {(HW-1){1'b0}}};
    else return {1'b0, {(HW-1){1'b1}}};
  endfunction

  logic [RW-1:0]        dvs;
  assign dvs = {cfg.facet_size, 1'b0};

  // products
  logic                 v1_r;
  logic signed [PW-1:0] p1_r, p2_r;
  side_t                s1_r;

  always_ff @(posedge clk) begin
    p1_r <= $signed({1'b0, job.m1}) * $signed(job.d1);
    p2_r <= $signed({1'b0, job.m2}) * $signed(job.d2);
    s1_r <= '{base: job.base, cur: job.cur, t: job.t, changed: job.changed};
  end

  // rounding numerator, sign folded
  logic                 v2_r;
  logic [NW-1:0]        nsum, nnum;
  logic [UW-1:0]        u2_r;
  logic                 neg2_r;
  side_t                s2_r;

  assign nsum = {{2{p1_r[PW-1]}}, p1_r} + {{2{p2_r[PW-1]}}, p2_r};
  assign nnum = {nsum[NW-2:0], 1'b0} + {{(NW-FACET_W){1'b0}}, cfg.facet_size};

  always_ff @(posedge clk) begin
    neg2_r <= nnum[NW-1];
    u2_r   <= nnum[NW-1] ? ~nnum[UW-1:0] : nnum[UW-1:0];
    s2_r   <= s1_r;
  end

  // divider stages, eight quotient bits each
  logic [UW-1:0] dvd_r [NDIV];
  logic [UW-1:0] quo_r [NDIV];
  logic [RW-1:0] rem_r [NDIV];
  logic          dneg_r [NDIV];
  side_t         ds_r [NDIV];
  logic          dv_r [NDIV];

  logic [UW-1:0]       src_dvd [NDIV];
  logic [UW-1:0]       src_quo [NDIV];
  logic [RW-1:0]       src_rem [NDIV];
  logic [RW+CH-1:0]    stp [NDIV];

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      if (k == 0) begin
        src_dvd[k] = u2_r;
        src_quo[k] = '0;
        src_rem[k] = '0;
      end else begin
        src_dvd[k] = dvd_r[k-1];
        src_quo[k] = quo_r[k-1];
        src_rem[k] = rem_r[k-1];
      end
      stp[k] = div_step(src_rem[k], src_dvd[k][UW-1:UW-CH], dvs);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIV; k++) begin
      dvd_r[k] <= {src_dvd[k][UW-CH-1:0], {CH{1'b0}}};
      quo_r[k] <= {src_quo[k][UW-CH-1:0], stp[k][CH-1:0]};
      rem_r[k] <= stp[k][RW+CH-1:CH];
      if (k == 0) begin
        dneg_r[k] <= neg2_r;
        ds_r[k]   <= s2_r;
      end else begin
        dneg_r[k] <= dneg_r[k-1];
        ds_r[k]   <= ds_r[k-1];
      end
    end
  end

  // facet height
  logic            v8_r;
  logic [UW-1:0]   qsig;
  logic [FW-1:0]   fsum;
  logic [HW-1:0]   facet8_r;
  side_t           s8_r;

  assign qsig = dneg_r[NDIV-1] ? ~quo_r[NDIV-1] : quo_r[NDIV-1];
  assign fsum = {{(FW-HW){ds_r[NDIV-1].base[HW-1]}}, ds_r[NDIV-1].base}
              + {{(FW-UW){qsig[UW-1]}}, qsig};

  always_ff @(posedge clk) begin
    facet8_r <= sat_hw(fsum);
    s8_r     <= ds_r[NDIV-1];
  end

  // blend product
  logic                  v9_r;
  logic [DW-1:0]         diff;
  logic signed [PRW-1:0] prod9_r;
  logic [HW-1:0]         facet9_r;
  side_t                 s9_r;

  assign diff = {facet8_r[HW-1], facet8_r} - {s8_r.cur[HW-1], s8_r.cur};

  always_ff @(posedge clk) begin
    prod9_r  <= $signed(diff) * $signed({1'b0, s8_r.t});
    facet9_r <= facet8_r;
    s9_r     <= s8_r;
  end

  // rounded blend and output register
  logic signed [PRW-1:0] prnd, pshift;
  logic [FW-1:0]         nh_sum;
  logic                  o_v_r;
  logic [HW-1:0]         o_nh_r, o_fh_r;
  logic                  o_chg_r;

  assign prnd   = prod9_r + RND_HALF;
  assign pshift = prnd >>> 16;
  assign nh_sum = {{(FW-HW){s9_r.cur[HW-1]}}, s9_r.cur} + pshift[FW-1:0];

  always_ff @(posedge clk) begin
    o_nh_r  <= s9_r.changed ? sat_hw(nh_sum) : s9_r.cur;
    o_fh_r  <= facet9_r;
    o_chg_r <= s9_r.changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      o_v_r <= 1'b0;
      for (int k = 0; k < NDIV; k++) dv_r[k] <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      for (int k = 0; k < NDIV; k++) begin
        if (k == 0) dv_r[k] <= v2_r;
        else dv_r[k] <= dv_r[k-1];
      end
      v8_r  <= dv_r[NDIV-1];
      v9_r  <= v8_r;
      o_v_r <= v9_r;
    end
  end

  assign res_strobe       = o_v_r;
  assign res_new_height   = o_nh_r;
  assign res_facet_height = o_fh_r;
  assign res_changed      = o_chg_r;

endmodule
`default_nettype wire

### rtl/facet_height_flatten.sv
// Top level of the facet height flatten block.
//
//  channel  | ports                              | transaction
//  ---------+------------------------------------+-------------------------------
//  input    | start, busy, in_*                  | start high while busy is low
//  result   | out_strobe, out_*                  | one cycle with out_strobe high
//  config   | psel, penable, pwrite, paddr, ...  | access phase, pready always high
//
// One pixel per cycle sustained while busy is low; the multipliers and the
// eight-bit divider stages are fully pipelined.
// Reset sets facet_size to 4, brush_strength to 1.0 and empties the job queue.
// The result channel has no stall; busy rises only if the job queue could fill.
`default_nettype none
`include "facet_height_flatten_assert.svh"
module facet_height_flatten import fhf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [POS_W-1:0]  in_pos_x,
  input  wire logic [POS_W-1:0]  in_pos_y,
  input  wire logic [HW-1:0]     in_height_a,
  input  wire logic [HW-1:0]     in_height_b,
  input  wire logic [HW-1:0]     in_height_c,
  input  wire logic [HW-1:0]     in_height_d,
  input  wire logic [HW-1:0]     in_current_height,
  input  wire logic [WT_W-1:0]   in_pixel_weight,
  output logic                   out_strobe,
  output logic [HW-1:0]          out_new_height,
  output logic [HW-1:0]          out_facet_height,
  output logic                   out_was_changed,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t              cfg;
  logic              acc;
  logic              q_push;
  job_t              q_in, q_head;
  qstat_t            q_stat;
  logic              q_pop;
  logic [INFL_W-1:0] inflight;

  fhf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy = ({1'b0, q_stat.count} + {{(QCNT_W+1-INFL_W){1'b0}}, inflight})
                >= (QCNT_W+1)'(QDEPTH);
  assign acc  = start & ~busy;

  fhf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .acc            (acc),
    .pos_x          (in_pos_x),
    .pos_y          (in_pos_y),
    .height_a       (in_height_a),
    .height_b       (in_height_b),
    .height_c       (in_height_c),
    .height_d       (in_height_d),
    .current_height (in_current_height),
    .pixel_weight   (in_pixel_weight),
    .push           (q_push),
    .job            (q_in),
    .inflight       (inflight)
  );

  fhf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  assign q_pop = ~q_stat.empty;

  fhf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .take             (q_pop),
    .job              (q_head),
    .res_strobe       (out_strobe),
    .res_new_height   (out_new_height),
    .res_facet_height (out_facet_height),
    .res_changed      (out_was_changed)
  );

  `FHF_ASSERT(a_queue_no_overflow, clk, rst_n, !(q_push && q_stat.full), "job queue overflow")
  `FHF_ASSERT(a_cfg_range, clk, rst_n, (cfg.facet_size >= FACET_MIN) && (cfg.facet_size <= MAX_FACET) && (cfg.strength <= STR_ONE), "config register out of range")
  `FHF_ASSERT_IMP(a_queue_drains, clk, rst_n, !q_stat.empty && !q_push, q_stat.count == $past(q_stat.count) - 1'b1, "job queue did not drain")

endmodule
`default_nettype wire
